FILE: rtl/core/tmcw_pkg.sv
// Shared types and constants of the text-mode console writer.
// Holds command codes, field widths, the controller state type and the
// command/status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package tmcw_pkg;

  // Field widths of the stream items
  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = CHAR_W + COLOR_W;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  // Character codes and reset attribute
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT       = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_READ      = 2'd3
  } tmcw_op_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_DRAIN,
    ST_BS_RD,
    ST_BS_WR,
    ST_CLEAR,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_RESP
  } tmcw_state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;     // capture the accepted transaction
    logic put_exec;     // store character / advance position
    logic scroll_step;  // one step of the row-up copy sweep
    logic fill_step;    // write one blank cell of the fill sweep
    logic fill_rst;     // blank cells use the reset attribute
    logic pos_home;     // position back to cell zero
    logic bs_read;      // step back and fetch the previous cell
    logic bs_write;     // blank the fetched cell, keep its attribute
    logic rd_issue;     // fetch the requested cell
    logic ld_out;       // load the result register
    logic ld_read;      // result carries the fetched cell
  } tmcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;     // result register can take a new transaction
    logic put_wrap;     // the pending put runs past the last cell
    logic pos_zero;     // write position is cell zero
    logic sweep_last;   // sweep counter is on the last cell
  } tmcw_stat_t;

endpackage

FILE: rtl/core/tmcw_ctrl.sv
// Sequencer of the text-mode console writer.
// Steps each command through its states and drives the datapath by
// command bundle. Depends on tmcw_pkg.
`timescale 1ns / 1ps

module tmcw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  tmcw_pkg::tmcw_op_t   in_op,
  input  tmcw_pkg::tmcw_stat_t stat,
  output tmcw_pkg::tmcw_cmd_t  cmd
);
  import tmcw_pkg::*;

  tmcw_state_t state_r, state_nxt;

  // State register; reset starts the screen clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
        cmd.fill_rst  = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          unique case (in_op)
            CMD_PUT:       state_nxt = ST_PUT;
            CMD_BACKSPACE: state_nxt = ST_BS_RD;
            CMD_CLEAR:     state_nxt = ST_CLEAR;
            CMD_READ:      state_nxt = ST_RD_ADDR;
            default:       state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PUT: begin
        cmd.put_exec = 1'b1;
        if (stat.put_wrap) begin
          state_nxt = ST_SCROLL;
        end else if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last pipelined write lands here
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_BS_RD: begin
        if (stat.pos_zero) begin
          if (stat.out_free) begin
            cmd.ld_out = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_RESP;
          end
        end else begin
          cmd.bs_read = 1'b1;
          state_nxt   = ST_BS_WR;
        end
      end
      ST_BS_WR: begin
        cmd.bs_write = 1'b1;
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_CLEAR: begin
        cmd.fill_step = 1'b1;
        cmd.pos_home  = 1'b1;
        if (stat.sweep_last) begin
          if (stat.out_free) begin
            cmd.ld_out = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        // fetched cell held until the result register frees up
        if (stat.out_free) begin
          cmd.ld_out  = 1'b1;
          cmd.ld_read = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

FILE: rtl/core/tmcw_dp.sv
// Datapath of the text-mode console writer: screen memory, write position,
// sweep counter, scroll copy pipeline, config register and result register.
// Depends on tmcw_pkg; driven by tmcw_ctrl.
`timescale 1ns / 1ps

module tmcw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tmcw_pkg::COLOR_W-1:0]     cfg_wr_data,
  input  logic [tmcw_pkg::CHAR_W-1:0]      in_char_code,
  input  logic [tmcw_pkg::COLOR_W-1:0]     in_color,
  input  logic [tmcw_pkg::ROW_W-1:0]       in_read_row,
  input  logic [tmcw_pkg::COL_W-1:0]       in_read_column,
  input  tmcw_pkg::tmcw_cmd_t              cmd,
  output tmcw_pkg::tmcw_stat_t             stat,
  input  logic                             out_tready,
  output logic                             out_valid,
  output logic [tmcw_pkg::CURSOR_W-1:0]    out_cursor_position,
  output logic [tmcw_pkg::CHAR_W-1:0]      out_read_char,
  output logic [tmcw_pkg::COLOR_W-1:0]     out_read_color,
  output logic                             out_scrolled
);
  import tmcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int MW    = ROW_W + $clog2(COLUMNS) + 2;

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] BOT_BASE  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

  // Screen memory: attribute in the high byte, character in the low byte
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] mem_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic [COLOR_W-1:0] default_color_r;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [AW-1:0]      sweep_idx_r;
  logic               sweep_last;
  logic               copy_src;
  logic               scrolled_r;

  logic [CHAR_W-1:0]  code_r;
  logic [COLOR_W-1:0] color_r;
  logic [AW-1:0]      rd_addr_r;
  logic               rd_ok_r;
  logic [MW-1:0]      rd_prod;
  logic               rd_ok;
  logic               is_nl, put_wrap;

  logic               wr_v_r;
  logic [AW-1:0]      wr_addr_r;
  logic               wr_copy_r;

  logic [COLOR_W-1:0] blank_color;

  logic                out_valid_r;
  logic [CURSOR_W-1:0] out_cursor_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic [COLOR_W-1:0]  out_color_r;
  logic                out_scrolled_r;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_color_r <= RESET_COLOR;
    end else if (cfg_wr_en) begin
      default_color_r <= cfg_wr_data;
    end
  end

  // Captured transaction and read address
  assign rd_ok   = (int'(in_read_row) < ROWS) && (int'(in_read_column) < COLUMNS);
  assign rd_prod = MW'(in_read_row) * MW'(COLUMNS) + MW'(in_read_column);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      code_r    <= in_char_code;
      color_r   <= in_color;
      rd_ok_r   <= rd_ok;
      rd_addr_r <= AW'(rd_prod);
    end
  end

  assign is_nl    = (code_r == NEWLINE_CODE);
  assign put_wrap = (row_r == LAST_ROW) && (is_nl || (col_r == LAST_COL));

  // Write position, kept as cell index plus row and column
  always_comb begin
    pos_nxt = pos_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.pos_home) begin
      pos_nxt = '0;
      col_nxt = '0;
      row_nxt = '0;
    end else if (cmd.put_exec) begin
      if (put_wrap) begin
        pos_nxt = BOT_BASE;
        col_nxt = '0;
        row_nxt = LAST_ROW;
      end else if (is_nl) begin
        pos_nxt = pos_r - AW'(col_r) + ROW_STEP;
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else if (col_r == LAST_COL) begin
        pos_nxt = pos_r + AW'(1);
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        pos_nxt = pos_r + AW'(1);
        col_nxt = col_r + CW'(1);
      end
    end else if (cmd.bs_read) begin
      pos_nxt = pos_r - AW'(1);
      if (col_r == '0) begin
        col_nxt = LAST_COL;
        row_nxt = row_r - RW'(1);
      end else begin
        col_nxt = col_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      scrolled_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cmd.latch_in) begin
        scrolled_r <= 1'b0;
      end else if (cmd.put_exec && put_wrap) begin
        scrolled_r <= 1'b1;
      end
    end
  end

  // Sweep counter for fill and scroll, wraps back to zero after the last cell
  assign sweep_last = (sweep_idx_r == LAST_CELL);
  assign copy_src   = (sweep_idx_r < BOT_BASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_idx_r <= '0;
    end else if (cmd.fill_step || cmd.scroll_step) begin
      sweep_idx_r <= sweep_last ? '0 : sweep_idx_r + AW'(1);
    end
  end

  // Scroll write stage: copies the fetched cell one row up, or blanks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_v_r <= 1'b0;
    end else begin
      wr_v_r <= cmd.scroll_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scroll_step) begin
      wr_addr_r <= sweep_idx_r;
      wr_copy_r <= copy_src;
    end
  end

  assign blank_color = cmd.fill_rst ? RESET_COLOR : default_color_r;

  // Memory write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = {color_r, code_r};
    if (wr_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_r;
      mem_wdata = wr_copy_r ? mem_q : {default_color_r, BLANK_CODE};
    end else if (cmd.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_idx_r;
      mem_wdata = {blank_color, BLANK_CODE};
    end else if (cmd.put_exec) begin
      mem_we    = !is_nl;
      mem_waddr = pos_r;
      mem_wdata = {color_r, code_r};
    end else if (cmd.bs_write) begin
      mem_we    = 1'b1;
      mem_waddr = pos_r;
      mem_wdata = {mem_q[CELL_W-1:CHAR_W], BLANK_CODE};
    end
  end

  // Memory read port select
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rd_addr_r;
    if (cmd.bs_read) begin
      mem_re    = 1'b1;
      mem_raddr = pos_r - AW'(1);
    end else if (cmd.rd_issue) begin
      mem_re    = 1'b1;
      mem_raddr = rd_addr_r;
    end else if (cmd.scroll_step) begin
      mem_re    = copy_src;
      mem_raddr = sweep_idx_r + ROW_STEP;
    end
  end

  // Screen memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_cursor_r   <= CURSOR_W'(pos_nxt);
      out_scrolled_r <= scrolled_r;
      if (cmd.ld_read && rd_ok_r) begin
        out_char_r  <= mem_q[CHAR_W-1:0];
        out_color_r <= mem_q[CELL_W-1:CHAR_W];
      end else begin
        out_char_r  <= '0;
        out_color_r <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_cursor_r;
  assign out_read_char       = out_char_r;
  assign out_read_color      = out_color_r;
  assign out_scrolled        = out_scrolled_r;

  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.put_wrap   = put_wrap;
  assign stat.pos_zero   = (pos_r == '0);
  assign stat.sweep_last = sweep_last;

  // Checks
  a_ld_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || out_tready))
    else $error("result loaded while the previous one is still held");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= LAST_CELL) && (col_r <= LAST_COL) && (row_r <= LAST_ROW))
    else $error("write position out of range");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({wr_v_r, cmd.fill_step, cmd.put_exec, cmd.bs_write}))
    else $error("two writers on the screen memory");

  a_wrap_home: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_exec && put_wrap) |=> (pos_r == BOT_BASE) && scrolled_r)
    else $error("scroll did not move the position to the bottom row");

  a_bs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bs_read |-> (pos_r != '0))
    else $error("backspace stepped back from cell zero");

endmodule

FILE: rtl/core/text_mode_console_writer.sv
// Top level of the text-mode console writer.
// Unpacks the stream payloads and joins tmcw_ctrl with tmcw_dp.
// Depends on tmcw_pkg, tmcw_ctrl and tmcw_dp.
//
// Usage:
//   in_*  : command stream, one transaction per command (put, backspace,
//           clear, read). in_tready is high only while the sequencer is idle.
//   out_* : one result transaction per command, held in an output register
//           so the next command is taken while a result waits.
//   cfg_* : write of the blank attribute; write only while the block is idle.
// Scroll and clear sweep the screen memory one cell a cycle through its
//   single write port; scroll overlaps the row-up read with the write.
// Reset: a clearing pass blanks every cell with attribute 7; in_tready
//   stays low meanwhile, config writes are taken.
// Stall: with out_tready low the result stays put and one further command
//   is worked until its result is ready, then the block waits.
`timescale 1ns / 1ps

module text_mode_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: blank attribute
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // command stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] command, [9:2] char_code, [17:10] color, [22:18] read_row,
  // [29:23] read_column, [31:30] zero
  input  logic [31:0] in_tdata,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [10:0] cursor_position, [18:11] read_char, [26:19] read_color,
  // [27] scrolled, [31:28] zero
  output logic [31:0] out_tdata
);
  import tmcw_pkg::*;

  tmcw_cmd_t  cmd;
  tmcw_stat_t stat;
  tmcw_op_t   in_op;

  logic [CURSOR_W-1:0] cursor;
  logic [CHAR_W-1:0]   rd_char;
  logic [COLOR_W-1:0]  rd_color;
  logic                scrolled;

  // Input payload unpack
  assign in_op = tmcw_op_t'(in_tdata[1:0]);

  tmcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_op),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_char_code        (in_tdata[9:2]),
    .in_color            (in_tdata[17:10]),
    .in_read_row         (in_tdata[22:18]),
    .in_read_column      (in_tdata[29:23]),
    .cmd                 (cmd),
    .stat                (stat),
    .out_tready          (out_tready),
    .out_valid           (out_tvalid),
    .out_cursor_position (cursor),
    .out_read_char       (rd_char),
    .out_read_color      (rd_color),
    .out_scrolled        (scrolled)
  );

  // Result payload pack
  assign out_tdata = {4'b0000, scrolled, rd_color, rd_char, cursor};

endmodule

FILE: tb/sv/text_mode_console_writer_tb.sv
// Self-checking testbench for text_mode_console_writer: directed and random
// command streams checked against a screen and cursor predictor kept in the bench.
// Depends on tmcw_pkg and the text_mode_console_writer RTL.
`timescale 1ns / 1ps

module text_mode_console_writer_tb;
  import tmcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  // worst case per command: full screen sweep, longest input gap and output stall
  localparam int ITEM_BOUND = 1500;
  localparam int LIMIT      = 4 * (ITEM_BOUND * (CELLS + 2 + 17 + 17 + 4) + CELLS + 100);

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CHAR_W-1:0]   chr;
    logic [COLOR_W-1:0]  attr;
    logic                scrolled;
  } console_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [1:0] command, [9:2] char_code, [17:10] color, [22:18] read_row,
  // [29:23] read_column, [31:30] zero
  logic [31:0] in_tdata = 32'h0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [10:0] cursor_position, [18:11] read_char, [26:19] read_color, [27] scrolled
  logic [31:0] out_tdata;

  // predictor state
  logic [CELL_W-1:0]  screen_model [CELLS];
  int                 cursor_pos;
  logic [COLOR_W-1:0] blank_attr;
  console_report_t    cell_reports_due [$];

  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  int stall_left = 0;
  bit bursts_on = 1'b1;

  text_mode_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side back-pressure: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (bursts_on && $urandom_range(0, 11) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare every result transaction with the oldest prediction
  always @(posedge clk) begin
    console_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cell_reports_due.size() == 0) begin
        $error("unexpected result transaction: tdata %h", out_tdata);
        errors++;
      end else begin
        want = cell_reports_due.pop_front();
        if (out_tdata[10:0] !== want.cursor) begin
          $error("cursor_position: expected %0d, got %0d", want.cursor, out_tdata[10:0]);
          errors++;
        end
        if (out_tdata[18:11] !== want.chr) begin
          $error("read_char: expected %h, got %h", want.chr, out_tdata[18:11]);
          errors++;
        end
        if (out_tdata[26:19] !== want.attr) begin
          $error("read_color: expected %h, got %h", want.attr, out_tdata[26:19]);
          errors++;
        end
        if (out_tdata[27] !== want.scrolled) begin
          $error("scrolled: expected %0d, got %0d", want.scrolled, out_tdata[27]);
          errors++;
        end
      end
    end
  end

  task automatic blank_cells(input int first, input int count, input logic [COLOR_W-1:0] attr);
    for (int i = first; i < first + count; i++) screen_model[i] = {attr, BLANK_CODE};
  endtask

  // predictor: update screen and cursor, queue the expected report
  task automatic step_console(input tmcw_op_t op, input logic [7:0] code,
                              input logic [7:0] attr, input logic [4:0] row,
                              input logic [6:0] col);
    console_report_t rep;
    rep = '0;
    case (op)
      CMD_PUT: begin
        if (code == NEWLINE_CODE) begin
          cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
        end else begin
          screen_model[cursor_pos] = {attr, code};
          cursor_pos++;
        end
        // ran past the last cell: rows move up, bottom row blanked
        if (cursor_pos >= CELLS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
          blank_cells(CELLS - COLUMNS, COLUMNS, blank_attr);
          cursor_pos -= COLUMNS;
          rep.scrolled = 1'b1;
        end
      end
      CMD_BACKSPACE: begin
        if (cursor_pos != 0) begin
          cursor_pos--;
          screen_model[cursor_pos] = {screen_model[cursor_pos][15:8], BLANK_CODE};
        end
      end
      CMD_CLEAR: begin
        blank_cells(0, CELLS, blank_attr);
        cursor_pos = 0;
      end
      default: begin
        if (row < ROWS && col < COLUMNS) begin
          rep.chr  = screen_model[row * COLUMNS + col][7:0];
          rep.attr = screen_model[row * COLUMNS + col][15:8];
        end
      end
    endcase
    rep.cursor = CURSOR_W'(cursor_pos);
    cell_reports_due.push_back(rep);
  endtask

  // one command transaction; tvalid stays high afterwards unless a gap follows
  task automatic send_command(input tmcw_op_t op, input logic [7:0] code,
                              input logic [7:0] attr, input logic [4:0] row,
                              input logic [6:0] col);
    int gap;
    if (bursts_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, col, row, attr, code, op};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    step_console(op, code, attr, row, col);
  endtask

  // write the blank attribute once the block has drained
  task automatic set_blank_color(input logic [7:0] attr);
    in_tvalid <= 1'b0;
    while (cell_reports_due.size() != 0 || !in_tready) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= attr;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    blank_attr = attr;
  endtask

  task automatic read_cell(input logic [4:0] row, input logic [6:0] col);
    send_command(CMD_READ, 8'($urandom), 8'($urandom), row, col);
  endtask

  task automatic put_char(input logic [7:0] code, input logic [7:0] attr);
    send_command(CMD_PUT, code, attr, 5'($urandom), 7'($urandom));
  endtask

  task automatic send_plain(input tmcw_op_t op);
    send_command(op, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
  endtask

  // read near the cursor, on the bottom row, anywhere, or with any field value
  task automatic read_somewhere();
    int pick;
    logic [4:0] r;
    logic [6:0] c;
    pick = $urandom_range(0, 9);
    r = 5'($urandom_range(0, ROWS - 1));
    c = 7'($urandom_range(0, COLUMNS - 1));
    if (pick < 4) r = 5'(cursor_pos / COLUMNS);
    else if (pick < 6) r = 5'(ROWS - 1);
    else if (pick == 9) begin
      r = 5'($urandom);
      c = 7'($urandom);
    end
    read_cell(r, c);
  endtask

  // screen after the power-on clearing pass
  task automatic test_power_on_screen();
    read_cell(5'd0, 7'd0);
    read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
  endtask

  // reads outside the screen return zero
  task automatic test_read_bounds();
    read_cell(5'(ROWS), 7'd0);
    read_cell(5'd0, 7'(COLUMNS));
    read_cell(5'h1f, 7'h7f);
  endtask

  // extreme characters and colors, newline without storing
  task automatic test_put_extremes();
    put_char(8'hff, 8'hff);
    put_char(8'h00, 8'h00);
    put_char(NEWLINE_CODE, 8'h5a);
    read_cell(5'd0, 7'd0);
    read_cell(5'd0, 7'd1);
    read_cell(5'd0, 7'd2);
  endtask

  // backspace keeps the attribute, and does nothing at cell zero
  task automatic test_backspace();
    send_plain(CMD_BACKSPACE);
    read_cell(5'd0, 7'(COLUMNS - 1));
    put_char(8'h55, 8'haa);
    send_plain(CMD_BACKSPACE);
    read_cell(5'd0, 7'(COLUMNS - 1));
    send_plain(CMD_CLEAR);
    send_plain(CMD_BACKSPACE);
  endtask

  // clear blanks with the programmed attribute
  task automatic test_clear_attr();
    set_blank_color(8'hff);
    put_char(8'h41, 8'h12);
    send_plain(CMD_CLEAR);
    read_cell(5'd0, 7'd0);
    read_cell(5'd12, 7'd40);
  endtask

  // random text: lines, newline runs, backspaces, reads, noise, rare clears
  task automatic test_text_phase(input int quota);
    int start;
    int kind;
    int n;
    start = items_sent;
    while (items_sent - start < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 40);
        for (int i = 0; i < n; i++) put_char(8'($urandom), 8'($urandom));
        put_char(NEWLINE_CODE, 8'($urandom));
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) read_somewhere();
      end else if (kind < 72) begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) put_char(NEWLINE_CODE, 8'($urandom));
        read_somewhere();
      end else if (kind < 84) begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) send_plain(CMD_BACKSPACE);
        read_cell(5'(cursor_pos / COLUMNS), 7'(cursor_pos % COLUMNS));
      end else if (kind < 94) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) read_somewhere();
      end else if (kind < 97) begin
        // noise: any field value, no clears
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 2))
            0: send_plain(CMD_PUT);
            1: send_plain(CMD_BACKSPACE);
            default: send_plain(CMD_READ);
          endcase
        end
      end else begin
        send_plain(CMD_CLEAR);
        read_somewhere();
      end
    end
  endtask

  initial begin
    blank_attr = RESET_COLOR;
    cursor_pos = 0;
    blank_cells(0, CELLS, RESET_COLOR);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    test_power_on_screen();
    test_read_bounds();
    test_put_extremes();
    test_backspace();
    test_clear_attr();

    test_text_phase(300);
    set_blank_color(8'h00);
    test_text_phase(300);
    set_blank_color(8'($urandom));
    test_text_phase(300);
    set_blank_color(RESET_COLOR);
    bursts_on <= 1'b0;
    test_text_phase(300);

    // drain and settle
    in_tvalid <= 1'b0;
    while (cell_reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tmcw_pkg.sv
rtl/core/tmcw_ctrl.sv
rtl/core/tmcw_dp.sv
rtl/core/text_mode_console_writer.sv
tb/sv/text_mode_console_writer_tb.sv
